@@ sv/i2cmts_pkg.sv @@
// Shared types, status codes and command codes for the I2C transaction sequencer
`timescale 1ns / 1ps
`default_nettype none

package i2cmts_pkg;

  // transaction kinds on the input side
  typedef enum logic [1:0] {
    FUNC_BEGIN    = 2'd0,
    FUNC_COMPLETE = 2'd1,
    FUNC_SUPPLY   = 2'd2,
    FUNC_UNUSED   = 2'd3
  } func_t;

  // byte engine commands
  typedef enum logic [2:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_SEND    = 3'd2,
    CMD_RX_ACK  = 3'd3,
    CMD_RX_NACK = 3'd4,
    CMD_STOP    = 3'd5
  } cmd_t;

  // sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_ADDR  = 3'd2,
    PH_DATA  = 3'd3,
    PH_HOST  = 3'd4,
    PH_STOP  = 3'd5
  } phase_t;

  // standard TWI status codes
  localparam logic [7:0] ST_START        = 8'h08;
  localparam logic [7:0] ST_MT_SLA_ACK   = 8'h18;
  localparam logic [7:0] ST_MT_DATA_ACK  = 8'h28;
  localparam logic [7:0] ST_MR_SLA_ACK   = 8'h40;
  localparam logic [7:0] ST_MR_DATA_ACK  = 8'h50;
  localparam logic [7:0] ST_MR_DATA_NACK = 8'h58;
  localparam logic [7:0] ST_BUS_ERROR    = 8'h00;

  // sequencer state
  typedef struct packed {
    phase_t      phase;
    logic        direction_read;
    logic [6:0]  slave_address;
    logic [7:0]  bytes_left;
    logic        pending_failed;
    logic [7:0]  pending_status;
  } seq_state_t;

  // one input transaction
  typedef struct packed {
    func_t       func;
    logic        read_not_write;
    logic [6:0]  target_address;
    logic [7:0]  byte_count;
    logic [7:0]  engine_status;
    logic [7:0]  received_byte;
    logic [7:0]  send_byte;
  } seq_in_t;

  // one result transaction
  typedef struct packed {
    cmd_t        engine_command;
    logic [7:0]  command_byte;
    logic        byte_request;
    logic        read_valid;
    logic [7:0]  read_data;
    logic        done_res;
    logic        failed;
    logic [7:0]  final_status;
  } seq_out_t;

endpackage

`default_nettype wire

@@ sv/i2c_master_transaction_sequencer_unit.sv @@
// Top level of the byte-level I2C master transaction sequencer
//
// Each input transaction (begin, engine completion or host write byte) yields
// exactly one result transaction holding the next byte engine command and any
// host-side report. One transaction is taken every clock cycle unless output
// stalls; the result appears in the cycle after acceptance from a single
// output register, and a new input is taken whenever that register is empty
// or being drained in the same cycle. The sequencer state lives in a handful
// of registers updated by the phase decision on every accepted transaction.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transaction_sequencer_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // input transactions
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // read_not_write, target_address[7], byte_count[8],
                                     // engine_status[8], received_byte[8], send_byte[8]
  input  wire logic [1:0]  s_tuser,  // func[2]
  // result transactions
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // command_byte[8], byte_request, read_valid,
                                     // read_data[8], done_res, failed, final_status[8],
                                     // zero fill[4]
  output logic [2:0]       m_tuser   // engine_command[3]
);
  import i2cmts_pkg::*;

  seq_state_t state;
  seq_state_t state_next;
  seq_in_t    item;
  seq_out_t   result;
  seq_out_t   out_reg;
  logic       accept;

  // unpack the input transaction
  assign item.func           = func_t'(s_tuser);
  assign item.read_not_write = s_tdata[0];
  assign item.target_address = s_tdata[7:1];
  assign item.byte_count     = s_tdata[15:8];
  assign item.engine_status  = s_tdata[23:16];
  assign item.received_byte  = s_tdata[31:24];
  assign item.send_byte      = s_tdata[39:32];

  assign s_tready = !m_tvalid || m_tready;
  assign accept   = s_tvalid && s_tready;

  i2cmts_step u_step (
    .state      (state),
    .item       (item),
    .state_next (state_next),
    .result     (result)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase          <= PH_IDLE;
      state.direction_read <= 1'b0;
      state.slave_address  <= 7'd0;
      state.bytes_left     <= 8'd0;
      state.pending_failed <= 1'b0;
      state.pending_status <= 8'd0;
    end else if (accept) begin
      state <= state_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (accept) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_reg <= result;
    end
  end

  // pack the result transaction
  assign m_tuser = out_reg.engine_command;
  assign m_tdata = {4'd0, out_reg.final_status, out_reg.failed, out_reg.done_res,
                    out_reg.read_data, out_reg.read_valid, out_reg.byte_request,
                    out_reg.command_byte};

endmodule

`default_nettype wire

@@ sv/i2cmts_step.sv @@
// Phase decision: next sequencer state and result for one input transaction
`timescale 1ns / 1ps
`default_nettype none

module i2cmts_step (
  input  i2cmts_pkg::seq_state_t state,
  input  i2cmts_pkg::seq_in_t    item,
  output i2cmts_pkg::seq_state_t state_next,
  output i2cmts_pkg::seq_out_t   result
);
  import i2cmts_pkg::*;

  logic [7:0] left_dec;
  logic [7:0] left_after;
  logic       addr_ok;
  logic       data_ok;
  logic       advance;

  // expected status checks for the address and data steps
  assign left_dec = state.bytes_left - 8'd1;
  assign addr_ok  = state.direction_read ? (item.engine_status == ST_MR_SLA_ACK)
                                         : (item.engine_status == ST_MT_SLA_ACK);
  assign data_ok  = state.direction_read ?
                    ((item.engine_status == ST_MR_DATA_ACK) ||
                     (item.engine_status == ST_MR_DATA_NACK)) :
                    (item.engine_status == ST_MT_DATA_ACK);

  // count seen by the next-byte decision
  assign left_after = (state.phase == PH_DATA) ? left_dec : state.bytes_left;

  // go on to the next byte after a good address or data completion
  assign advance = (item.func == FUNC_COMPLETE) &&
                   (((state.phase == PH_ADDR) && addr_ok) ||
                    ((state.phase == PH_DATA) && data_ok));

  always_comb begin
    state_next = state;
    result     = '0;
    unique case (item.func)
      FUNC_BEGIN: begin
        if (state.phase == PH_IDLE) begin
          state_next.direction_read = item.read_not_write;
          state_next.slave_address  = item.target_address;
          state_next.bytes_left     = item.byte_count;
          state_next.pending_failed = 1'b0;
          state_next.pending_status = 8'd0;
          state_next.phase          = PH_START;
          result.engine_command     = CMD_START;
        end
      end
      FUNC_COMPLETE: begin
        unique case (state.phase)
          PH_START: begin
            if (item.engine_status == ST_START) begin
              result.engine_command = CMD_SEND;
              result.command_byte   = {state.slave_address, state.direction_read};
              state_next.phase      = PH_ADDR;
            end else if (item.engine_status == ST_BUS_ERROR) begin
              // bus error still gets a stop before reporting
              result.engine_command     = CMD_STOP;
              state_next.pending_failed = 1'b1;
              state_next.pending_status = item.engine_status;
              state_next.phase          = PH_STOP;
            end else begin
              result.done_res     = 1'b1;
              result.failed       = 1'b1;
              result.final_status = item.engine_status;
              state_next.phase    = PH_IDLE;
            end
          end
          PH_ADDR, PH_DATA: begin
            if (!advance) begin
              result.engine_command     = CMD_STOP;
              state_next.pending_failed = 1'b1;
              state_next.pending_status = item.engine_status;
              state_next.phase          = PH_STOP;
            end
          end
          PH_STOP: begin
            result.done_res     = 1'b1;
            result.failed       = state.pending_failed;
            result.final_status = state.pending_status;
            state_next.phase    = PH_IDLE;
          end
          default: begin
          end
        endcase
      end
      FUNC_SUPPLY: begin
        if (state.phase == PH_HOST) begin
          result.engine_command = CMD_SEND;
          result.command_byte   = item.send_byte;
          state_next.phase      = PH_DATA;
        end
      end
      default: begin
      end
    endcase

    // next-byte decision after a successful step
    if (advance) begin
      state_next.bytes_left = left_after;
      if ((state.phase == PH_DATA) && state.direction_read) begin
        result.read_valid = 1'b1;
        result.read_data  = item.received_byte;
      end
      if (left_after == 8'd0) begin
        result.engine_command     = CMD_STOP;
        state_next.pending_failed = 1'b0;
        state_next.pending_status = 8'd0;
        state_next.phase          = PH_STOP;
      end else if (state.direction_read) begin
        result.engine_command = (left_after > 8'd1) ? CMD_RX_ACK : CMD_RX_NACK;
        state_next.phase      = PH_DATA;
      end else begin
        result.byte_request = 1'b1;
        state_next.phase    = PH_HOST;
      end
    end
  end

endmodule

`default_nettype wire

@@ bench/tb.sv @@
// Self-checking bench for the I2C master transaction sequencer with random stream handshakes
`timescale 1ns / 1ps

module tb;
  import i2cmts_pkg::*;

  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int STALL_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [2:0]  m_tuser;

  i2c_master_transaction_sequencer_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  seq_in_t    pending_items[$];
  seq_out_t   expected_results[$];
  seq_state_t plan_state;   // state seen by the stimulus generator
  seq_state_t track_state;  // state advanced on accepted transactions
  seq_in_t    offered_item;
  int         total_items = 0;
  int         n_taken = 0;
  int         n_errors = 0;
  int         stall_left = 0;
  bit         stall_done = 1'b0;
  bit         take;

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // end the transfer with a stop command and remember the outcome
  function automatic void issue_stop(inout seq_state_t st, inout seq_out_t r,
                                     input logic fail, input logic [7:0] status);
    r.engine_command = CMD_STOP;
    st.pending_failed = fail;
    st.pending_status = status;
    st.phase = PH_STOP;
  endfunction

  // step to the next data byte, or to stop when none is left
  function automatic void advance_byte(inout seq_state_t st, inout seq_out_t r);
    if (st.bytes_left == 8'd0) begin
      issue_stop(st, r, 1'b0, 8'h00);
    end else if (st.direction_read) begin
      if (st.bytes_left > 8'd1) r.engine_command = CMD_RX_ACK;
      else r.engine_command = CMD_RX_NACK;
      st.phase = PH_DATA;
    end else begin
      r.byte_request = 1'b1;
      st.phase = PH_HOST;
    end
  endfunction

  // next command and host report for one input transaction
  function automatic seq_out_t sequence_step(inout seq_state_t st, input seq_in_t it);
    seq_out_t   r;
    logic [7:0] sla_ack;
    r = '0;
    case (it.func)
      FUNC_BEGIN: begin
        if (st.phase == PH_IDLE) begin
          st.direction_read = it.read_not_write;
          st.slave_address = it.target_address;
          st.bytes_left = it.byte_count;
          st.pending_failed = 1'b0;
          st.pending_status = 8'h00;
          r.engine_command = CMD_START;
          st.phase = PH_START;
        end
      end
      FUNC_COMPLETE: begin
        case (st.phase)
          PH_START: begin
            if (it.engine_status == ST_START) begin
              r.engine_command = CMD_SEND;
              r.command_byte = {st.slave_address, st.direction_read};
              st.phase = PH_ADDR;
            end else if (it.engine_status == ST_BUS_ERROR) begin
              issue_stop(st, r, 1'b1, it.engine_status);
            end else begin
              r.done_res = 1'b1;
              r.failed = 1'b1;
              r.final_status = it.engine_status;
              st.phase = PH_IDLE;
            end
          end
          PH_ADDR: begin
            sla_ack = st.direction_read ? ST_MR_SLA_ACK : ST_MT_SLA_ACK;
            if (it.engine_status != sla_ack) issue_stop(st, r, 1'b1, it.engine_status);
            else advance_byte(st, r);
          end
          PH_DATA: begin
            if (st.direction_read && (it.engine_status == ST_MR_DATA_ACK ||
                                      it.engine_status == ST_MR_DATA_NACK)) begin
              r.read_valid = 1'b1;
              r.read_data = it.received_byte;
              st.bytes_left = st.bytes_left - 8'd1;
              advance_byte(st, r);
            end else if (!st.direction_read && it.engine_status == ST_MT_DATA_ACK) begin
              st.bytes_left = st.bytes_left - 8'd1;
              advance_byte(st, r);
            end else begin
              issue_stop(st, r, 1'b1, it.engine_status);
            end
          end
          PH_STOP: begin
            r.done_res = 1'b1;
            r.failed = st.pending_failed;
            r.final_status = st.pending_status;
            st.phase = PH_IDLE;
          end
          default: ;
        endcase
      end
      FUNC_SUPPLY: begin
        if (st.phase == PH_HOST) begin
          r.engine_command = CMD_SEND;
          r.command_byte = it.send_byte;
          st.phase = PH_DATA;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // queue a transaction and tell whether the sequencer acts on it
  task automatic queue_item(input seq_in_t it, output bit acted);
    seq_out_t r;
    r = sequence_step(plan_state, it);
    pending_items.push_back(it);
    acted = (r != '0);
  endtask

  task automatic add_item(input func_t f, input logic rnw, input logic [6:0] adr,
                          input logic [7:0] cnt, input logic [7:0] sts,
                          input logic [7:0] rx, input logic [7:0] tx);
    seq_in_t it;
    bit      acted;
    it.func = f;
    it.read_not_write = rnw;
    it.target_address = adr;
    it.byte_count = cnt;
    it.engine_status = sts;
    it.received_byte = rx;
    it.send_byte = tx;
    queue_item(it, acted);
  endtask

  // mostly well-formed transfers with random content, some noise and broken steps
  task automatic add_random_item(output bit acted);
    seq_in_t it;
    int      roll;
    int      len_roll;
    it.func = func_t'(2'($urandom_range(0, 3)));
    it.read_not_write = 1'($urandom_range(0, 1));
    it.target_address = 7'($urandom_range(0, 127));
    it.byte_count = 8'($urandom_range(0, 255));
    it.engine_status = 8'($urandom_range(0, 255));
    it.received_byte = 8'($urandom_range(0, 255));
    it.send_byte = 8'($urandom_range(0, 255));
    roll = $urandom_range(0, 99);
    case (plan_state.phase)
      PH_IDLE: begin
        if (roll < 90) begin
          it.func = FUNC_BEGIN;
          len_roll = $urandom_range(0, 63);
          if (len_roll == 0) it.byte_count = 8'd255;
          else if (len_roll < 3) it.byte_count = 8'($urandom_range(16, 255));
          else it.byte_count = 8'($urandom_range(0, 4));
        end
      end
      PH_START: begin
        if (roll < 95) it.func = FUNC_COMPLETE;
        if (roll < 85) it.engine_status = ST_START;
        else if (roll < 91) it.engine_status = ST_BUS_ERROR;
      end
      PH_ADDR: begin
        if (roll < 95) it.func = FUNC_COMPLETE;
        if (roll < 88)
          it.engine_status = plan_state.direction_read ? ST_MR_SLA_ACK : ST_MT_SLA_ACK;
      end
      PH_DATA: begin
        if (roll < 96) it.func = FUNC_COMPLETE;
        if (roll < 92) begin
          if (!plan_state.direction_read) it.engine_status = ST_MT_DATA_ACK;
          else if ($urandom_range(0, 1)) it.engine_status = ST_MR_DATA_ACK;
          else it.engine_status = ST_MR_DATA_NACK;
        end
      end
      PH_HOST: begin
        if (roll < 88) it.func = FUNC_SUPPLY;
      end
      default: begin
        if (roll < 90) it.func = FUNC_COMPLETE;
      end
    endcase
    queue_item(it, acted);
  endtask

  // idle percentage per side: sender light first, then receiver light, then none
  function automatic int idle_pct(input bit receiver);
    if (n_taken < total_items / 3) return receiver ? 79 : 26;
    if (n_taken < (2 * total_items) / 3) return receiver ? 26 : 79;
    return 0;
  endfunction

  // driver: offer queued transactions, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      take = s_tvalid && s_tready;
      if (take) begin
        expected_results.push_back(sequence_step(track_state, offered_item));
        n_taken++;
      end
      if (!s_tvalid || take) begin
        if (pending_items.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          offered_item = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {offered_item.send_byte, offered_item.received_byte,
                      offered_item.engine_status, offered_item.byte_count,
                      offered_item.target_address, offered_item.read_not_write};
          s_tuser <= offered_item.func;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: random ready, plus one long hold-off halfway through
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (!stall_done && n_taken >= total_items / 2) begin
        stall_done = 1'b1;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
      end
    end
  end

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      n_errors++;
    end
  endtask

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    seq_out_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        $error("result transaction with no prediction pending: %h / %h", m_tuser, m_tdata);
        n_errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("engine_command", 8'(want.engine_command), 8'(m_tuser));
        check_field("command_byte", want.command_byte, m_tdata[7:0]);
        check_field("byte_request", 8'(want.byte_request), 8'(m_tdata[8]));
        check_field("read_valid", 8'(want.read_valid), 8'(m_tdata[9]));
        check_field("read_data", want.read_data, m_tdata[17:10]);
        check_field("done_res", 8'(want.done_res), 8'(m_tdata[18]));
        check_field("failed", 8'(want.failed), 8'(m_tdata[19]));
        check_field("final_status", want.final_status, m_tdata[27:20]);
        check_field("zero fill", 8'h00, 8'(m_tdata[31:28]));
      end
    end
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  // stimulus and end of run
  initial begin
    int n_acted;
    bit acted;
    plan_state = '0;
    plan_state.phase = PH_IDLE;
    track_state = plan_state;

    // write one byte to the top address, stray completion while the host byte is due
    add_item(FUNC_BEGIN, 1'b0, 7'h7F, 8'd1, 8'h00, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, ST_START, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, ST_MT_SLA_ACK, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b1, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_item(FUNC_SUPPLY, 1'b0, 7'h00, 8'h00, 8'h00, 8'h00, 8'hFF);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, ST_MT_DATA_ACK, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, 8'hFF, 8'h00, 8'h00);
    // read two bytes from address zero, with a begin while busy
    add_item(FUNC_BEGIN, 1'b1, 7'h00, 8'd2, 8'h00, 8'h00, 8'h00);
    add_item(FUNC_BEGIN, 1'b0, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, ST_START, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, ST_MR_SLA_ACK, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, ST_MR_DATA_ACK, 8'hA5, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, ST_MR_DATA_NACK, 8'h5A, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    // zero length write goes straight to stop
    add_item(FUNC_BEGIN, 1'b0, 7'h55, 8'd0, 8'h00, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, ST_START, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, ST_MT_SLA_ACK, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, 8'h3C, 8'h00, 8'h00);
    // bus error on start still issues stop
    add_item(FUNC_BEGIN, 1'b1, 7'h2A, 8'd3, 8'h00, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, ST_BUS_ERROR, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, 8'hC3, 8'h00, 8'h00);
    // any other failed start ends at once
    add_item(FUNC_BEGIN, 1'b0, 7'h11, 8'd5, 8'h00, 8'h00, 8'h00);
    add_item(FUNC_COMPLETE, 1'b0, 7'h00, 8'h00, 8'hF8, 8'h00, 8'h00);
    // ignored while idle: completion, host byte, unused code
    add_item(FUNC_COMPLETE, 1'b1, 7'h7F, 8'hFF, ST_START, 8'hFF, 8'hFF);
    add_item(FUNC_SUPPLY, 1'b1, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    add_item(FUNC_UNUSED, 1'b1, 7'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    n_acted = 0;
    while (n_acted < RANDOM_ITEMS) begin
      add_random_item(acted);
      if (acted) n_acted++;
    end
    total_items = pending_items.size();

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ i2c_master_transaction_sequencer_unit.f @@
sv/i2cmts_pkg.sv
sv/i2cmts_step.sv
sv/i2c_master_transaction_sequencer_unit.sv
bench/tb.sv
